@@ rtl/core/numerov_pkg.sv @@
// ----------------------------------------------------------------------------
// numerov_pkg
// widths, codes and shared types of the numerov ode stepper
// ----------------------------------------------------------------------------
`default_nettype none

package numerov_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 65;
    localparam int HF_W      = 48;
    localparam int COEF_W    = 50;
    localparam int DVS_W     = 46;
    localparam int DIVQ_W    = 48;
    localparam int ACC_W     = 84;
    localparam int CNT_W     = 6;

    localparam int DIV3_CYCLES = DIVQ_W / 8;
    localparam int GEN_CYCLES  = DATA_W;

    localparam logic [2:0] CONST_THREE = 3'd3;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 50'sd4294967296;
    localparam logic signed [COEF_W-1:0] COEF_TWO = 50'sd8589934592;

    localparam logic [DATA_W-1:0] Y_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] Y_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_VAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_VAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS = 3'd5;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef enum logic {
        DM_CONST3  = 1'b0,
        DM_GENERAL = 1'b1
    } t_div_mode;

    typedef struct packed {
        logic              start;
        t_div_mode         mode;
        logic [DVS_W-1:0]  rem_init;
        logic [DIVQ_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

endpackage

`default_nettype wire

@@ rtl/core/numerov_mul.sv @@
// ----------------------------------------------------------------------------
// numerov_mul
// shared signed 33 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module numerov_mul import numerov_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic signed [DATA_W:0]    i_a,
    input  wire logic signed [DATA_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]       o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/core/numerov_div.sv @@
// ----------------------------------------------------------------------------
// numerov_div
// shared iterative divider: divide by three eight bits a cycle, or restoring
// division one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module numerov_div import numerov_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [DIVQ_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    t_div_mode         r_mode;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIVQ_W-1:0] r_sh;

    logic [1:0]        c_r;
    logic [2:0]        c_t;
    logic [7:0]        c_q;
    logic [DVS_W:0]    g_t;
    logic              g_ge;
    logic [DVS_W-1:0]  g_rem;
    logic [CNT_W-1:0]  cnt_last;

    // divide by three, msb first, small remainder
    always_comb begin
        c_r = r_rem[1:0];
        c_t = '0;
        c_q = '0;
        for (int i = 0; i < 8; i++) begin
            c_t = {c_r, r_sh[DIVQ_W-1-i]};
            c_q[7-i] = (c_t >= CONST_THREE);
            c_r = c_q[7-i] ? 2'(c_t - CONST_THREE) : c_t[1:0];
        end
    end

    always_comb begin
        g_t   = {r_rem, r_sh[DIVQ_W-1]};
        g_ge  = (g_t >= {1'b0, r_dvs});
        g_rem = g_ge ? DVS_W'(g_t - {1'b0, r_dvs}) : g_t[DVS_W-1:0];
    end

    assign cnt_last = (r_mode == DM_CONST3) ? CNT_W'(DIV3_CYCLES - 1) : CNT_W'(GEN_CYCLES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cnt_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_rem  <= (i_req.mode == DM_CONST3) ? '0 : i_req.rem_init;
            r_dvs  <= i_req.divisor;
            r_sh   <= i_req.dividend;
        end else if (r_busy) begin
            if (r_mode == DM_CONST3) begin
                r_rem <= {{(DVS_W-2){1'b0}}, c_r};
                r_sh  <= {r_sh[DIVQ_W-9:0], c_q};
            end else begin
                r_rem <= g_rem;
                r_sh  <= {r_sh[DIVQ_W-2:0], g_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

`default_nettype wire

@@ rtl/core/numerov_ode_stepper.sv @@
// ----------------------------------------------------------------------------
// numerov_ode_stepper
// numerov integrator for y'' = -f(r) y in q16.16 fixed point
// ----------------------------------------------------------------------------
// One f sample per input beat gives one output beat with the grid position
// and y at that point. Points 0 and 1 of a run return the programmed start
// values. Every later point takes three passes of h^2 f through the shared
// multiplier, each followed by a divide by three in the shared divider, four
// partial products for the numerator, then a restoring division by the
// divisor term. s_axis_tready is low while a point is in work; a finished
// beat waits in the output register and the next sample is taken meanwhile.
// tlast marks the point num_steps, and the next sample starts a new run.
// Overflow saturates with status 1, a non-positive divisor gives y = 0 with
// status 2. Registers are to be written only between points; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module numerov_ode_stepper import numerov_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0]     i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DATA_W-1:0]     s_axis_tdata,   // f_sample
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [2*DATA_W-1:0]        m_axis_tdata,   // position, value
    output logic                       m_axis_tlast,
    output logic [1:0]                 m_axis_tuser    // status
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_HMUL   = 11'b000_0000_0010,
        S_HDIV   = 11'b000_0000_0100,
        S_HWAIT  = 11'b000_0000_1000,
        S_COEF   = 11'b000_0001_0000,
        S_NMUL   = 11'b000_0010_0000,
        S_NACC   = 11'b000_0100_0000,
        S_ABS    = 11'b000_1000_0000,
        S_DSTART = 11'b001_0000_0000,
        S_DWAIT  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_step_sq, r_start_pos, r_grid_step, r_first_val, r_second_val;
    logic [IDX_W-1:0]  r_num_steps;

    logic [DATA_W-1:0] r_yb1, r_yb2, r_fb1, r_fb2, r_pos_acc;
    logic [IDX_W-1:0]  r_pidx;

    logic [DATA_W-1:0]        r_f0;
    logic [1:0]               r_k;
    logic [1:0]               r_j;
    logic signed [HF_W-1:0]   r_hf;
    logic signed [COEF_W-1:0] r_c0, r_c1, r_d;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_y;
    t_status                  r_status;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_pos, r_out_val;
    logic                r_out_last;
    t_status             r_out_status;

    logic signed [DATA_W:0]   mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [COEF_W-1:0] c_sel;
    logic [DATA_W-1:0]        y_sel;

    t_div_req            div_req;
    logic                w_div_done;
    logic [DIVQ_W-1:0]   w_quot;

    logic signed [HF_W-1:0]   hf;
    logic [HF_W-1:0]          hf_mag;
    logic signed [COEF_W-1:0] sq6, sq12;
    logic signed [ACC_W-1:0]  prod_ext, term;
    logic [ACC_W-DATA_W-1:0]  num_hi;
    logic                     num_sat;
    logic [DATA_W-1:0]        q_lim, q_sat, y_div;
    logic                     q_over;
    logic                     out_free;
    logic                     is_last;
    logic                     early_pt;

    assign out_free = !r_out_valid || m_axis_tready;
    assign is_last  = (r_pidx >= r_num_steps);
    assign early_pt = (r_pidx[IDX_W-1:1] == '0);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_sq    <= '0;
            r_start_pos  <= '0;
            r_grid_step  <= '0;
            r_first_val  <= '0;
            r_second_val <= '0;
            r_num_steps  <= IDX_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_SQ:    r_step_sq    <= i_cfg_data;
                REG_START_POS:  r_start_pos  <= i_cfg_data;
                REG_GRID_STEP:  r_grid_step  <= i_cfg_data;
                REG_FIRST_VAL:  r_first_val  <= i_cfg_data;
                REG_SECOND_VAL: r_second_val <= i_cfg_data;
                REG_NUM_STEPS:  r_num_steps  <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        c_sel = r_j[1] ? r_c1 : r_c0;
        y_sel = r_j[1] ? r_yb2 : r_yb1;
        mul_a = {1'b0, r_step_sq};
        case (r_k)
            2'd0:    mul_b = r_f0;
            2'd1:    mul_b = r_fb1;
            default: mul_b = r_fb2;
        endcase
        if (r_state == S_NMUL) begin
            mul_a = r_j[0] ? {{(DATA_W+1-(COEF_W-DATA_W)){c_sel[COEF_W-1]}},
                              c_sel[COEF_W-1:DATA_W]}
                           : {1'b0, c_sel[DATA_W-1:0]};
            mul_b = y_sel;
        end
    end

    numerov_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (w_prod)
    );

    // h^2 f and its scaled terms
    always_comb begin
        hf     = w_prod[FRAC_BITS+HF_W-1:FRAC_BITS];
        hf_mag = hf[HF_W-1] ? HF_W'(-hf) : hf;
        sq6    = r_hf[HF_W-1] ? -$signed({2'b0, w_quot}) : $signed({2'b0, w_quot});
        sq12   = r_hf[HF_W-1] ? -$signed({3'b0, w_quot[DIVQ_W-1:1]})
                              :  $signed({3'b0, w_quot[DIVQ_W-1:1]});
    end

    // numerator terms and final quotient
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
        term     = r_j[0] ? (prod_ext << DATA_W) : prod_ext;
        num_hi   = r_acc[ACC_W-1:DATA_W];
        num_sat  = (num_hi >= {{(ACC_W-DATA_W-DVS_W){1'b0}}, r_d[DVS_W-1:0]});
        q_lim    = r_neg ? Y_MIN : Y_MAX;
        q_over   = (w_quot[DATA_W-1:0] > q_lim);
        q_sat    = q_over ? q_lim : w_quot[DATA_W-1:0];
        y_div    = r_neg ? DATA_W'(-q_sat) : q_sat;
    end

    always_comb begin
        div_req          = '0;
        div_req.mode     = DM_CONST3;
        div_req.dividend = {1'b0, hf_mag[HF_W-1:1]};
        div_req.divisor  = r_d[DVS_W-1:0];
        if (r_state == S_HDIV) begin
            div_req.start = 1'b1;
        end else if (r_state == S_DSTART) begin
            div_req.start    = !num_sat;
            div_req.mode     = DM_GENERAL;
            div_req.rem_init = r_acc[DATA_W+DVS_W-1:DATA_W];
            div_req.dividend = {r_acc[DATA_W-1:0], {(DIVQ_W-DATA_W){1'b0}}};
        end
    end

    numerov_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = early_pt ? S_DONE : S_HMUL;
            S_HMUL:   n_state = S_HDIV;
            S_HDIV:   n_state = S_HWAIT;
            S_HWAIT:  if (w_div_done) n_state = (r_k == 2'd2) ? S_COEF : S_HMUL;
            S_COEF:   n_state = (r_d <= 0) ? S_DONE : S_NMUL;
            S_NMUL:   n_state = S_NACC;
            S_NACC:   n_state = (r_j == 2'd3) ? S_ABS : S_NMUL;
            S_ABS:    n_state = S_DSTART;
            S_DSTART: n_state = num_sat ? S_DONE : S_DWAIT;
            S_DWAIT:  if (w_div_done) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_f0     <= s_axis_tdata;
                r_k      <= '0;
                r_status <= ST_OK;
            end
            S_HDIV: begin
                r_hf <= hf;
            end
            S_HWAIT: begin
                if (w_div_done) begin
                    r_k <= r_k + 1'b1;
                    case (r_k)
                        2'd0:    r_d  <= COEF_ONE + sq12;
                        2'd1:    r_c0 <= COEF_TWO - {{(COEF_W-HF_W){r_hf[HF_W-1]}}, r_hf} + sq6;
                        default: r_c1 <= COEF_ONE + sq12;
                    endcase
                end
            end
            S_COEF: begin
                r_acc <= '0;
                r_j   <= '0;
                if (r_d <= 0) begin
                    r_y      <= '0;
                    r_status <= ST_DIVZ;
                end
            end
            S_NACC: begin
                r_acc <= r_j[1] ? r_acc - term : r_acc + term;
                r_j   <= r_j + 1'b1;
            end
            S_ABS: begin
                r_neg <= r_acc[ACC_W-1];
                r_acc <= r_acc[ACC_W-1] ? -r_acc : r_acc;
            end
            S_DSTART: begin
                if (num_sat) begin
                    r_y      <= r_neg ? Y_MIN : Y_MAX;
                    r_status <= ST_SAT;
                end
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    r_y      <= y_div;
                    r_status <= q_over ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end

    // history and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yb1       <= '0;
            r_yb2       <= '0;
            r_fb1       <= '0;
            r_fb2       <= '0;
            r_pidx      <= '0;
            r_pos_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_last  <= is_last;
                r_out_pos   <= (r_pidx == '0) ? r_start_pos : r_pos_acc;
                r_pos_acc   <= ((r_pidx == '0) ? r_start_pos : r_pos_acc) + r_grid_step;
                r_yb2       <= r_yb1;
                r_fb2       <= r_fb1;
                r_fb1       <= r_f0;
                r_pidx      <= is_last ? '0 : r_pidx + 1'b1;
                if (r_pidx == '0) begin
                    r_out_val    <= r_first_val;
                    r_yb1        <= r_first_val;
                    r_out_status <= ST_OK;
                end else if (early_pt) begin
                    r_out_val    <= r_second_val;
                    r_yb1        <= r_second_val;
                    r_out_status <= ST_OK;
                end else begin
                    r_out_val    <= r_y;
                    r_yb1        <= r_y;
                    r_out_status <= r_status;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_val, r_out_pos};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again while a point is in work");

    a_divz_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_DIVZ) |-> (m_axis_tdata[2*DATA_W-1:DATA_W] == '0))
        else $error("non-positive divisor beat with nonzero value");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
        (m_axis_tdata[2*DATA_W-1:DATA_W] == Y_MAX || m_axis_tdata[2*DATA_W-1:DATA_W] == Y_MIN))
        else $error("saturated beat not at a bound");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_HWAIT || r_state == S_DWAIT))
        else $error("divider finished outside a wait state");

    a_run_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && is_last) |=> (r_pidx == '0))
        else $error("point index not cleared after last point");

endmodule

`default_nettype wire

@@ bench/numerov_ode_stepper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numerov_ode_stepper_tb
// self-checking bench for the numerov ode stepper
// ----------------------------------------------------------------------------
// Streams f samples into the stepper and checks every output beat, field by
// field, against a bit-exact model of the q16.16 numerov recurrence kept in
// the bench or against the values of a directed row. A short table of
// directed rows (start values, extremes, saturation both ways, non-positive
// divisor, zero step count, ignored register indexes) runs first, then
// several phases of random samples under different register settings. Both
// sides idle at random; one phase runs with no idling and one holds the
// output off long enough to stall the input side.
// ----------------------------------------------------------------------------

module numerov_ode_stepper_tb;
    import numerov_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 100;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 220;
    localparam int CALM_PHASE   = 3;
    localparam int HOLD_PHASE   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam longint Q32_ONE = 64'sd4294967296;
    localparam longint Q32_TWO = 64'sd8589934592;
    localparam logic signed [127:0] Q_MAX = 128'sh7fff_ffff;
    localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] val;
        logic              last;
        t_status           st;
    } point_t;

    typedef struct {
        logic [DATA_W-1:0] f;
        logic              typed;
        point_t            want;
    } sample_t;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
        sample_t              smp;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DATA_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;   // f_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*DATA_W-1:0]  m_axis_tdata;         // position, value
    logic                 m_axis_tlast;
    logic [1:0]           m_axis_tuser;         // status

    numerov_ode_stepper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // register copies
    logic [DATA_W-1:0] cf_step_sq    = '0;
    logic [DATA_W-1:0] cf_start_pos  = '0;
    logic [DATA_W-1:0] cf_grid_step  = '0;
    logic [DATA_W-1:0] cf_first_val  = '0;
    logic [DATA_W-1:0] cf_second_val = '0;
    logic [IDX_W-1:0]  cf_num_steps  = 16'd1;

    // recurrence state
    logic [DATA_W-1:0] nm_y1      = '0;
    logic [DATA_W-1:0] nm_y2      = '0;
    logic [DATA_W-1:0] nm_f1      = '0;
    logic [DATA_W-1:0] nm_f2      = '0;
    logic [IDX_W-1:0]  nm_index   = '0;
    logic [DATA_W-1:0] nm_pos_acc = '0;

    sample_t f_backlog[$];
    point_t  expected_points[$];
    row_t    dir_rows[$];
    sample_t cur_sample;
    point_t  got_point;
    point_t  want_point;

    logic calm        = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_served = 1'b0;
    int   hold_left   = 0;
    int   mismatches  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint h2_times_f(input logic [DATA_W-1:0] fs);
        longint raw;
        raw = longint'({32'h0, cf_step_sq}) * longint'($signed(fs));
        return raw >>> FRAC_BITS;
    endfunction

    function automatic point_t numerov_next(input logic [DATA_W-1:0] f);
        point_t r;
        longint hf0, hf1, hf2, c0, c1, dn;
        logic signed [127:0] a0, a1, b0, b1, num, dv, quo;
        logic last_pt;
        last_pt = (nm_index >= cf_num_steps);
        r.st = ST_OK;
        if (nm_index == '0) begin
            r.pos      = cf_start_pos;
            nm_pos_acc = cf_start_pos + cf_grid_step;
            r.val      = cf_first_val;
        end else begin
            r.pos      = nm_pos_acc;
            nm_pos_acc = nm_pos_acc + cf_grid_step;
            if (nm_index == 16'd1) begin
                r.val = cf_second_val;
            end else begin
                hf0 = h2_times_f(f);
                hf1 = h2_times_f(nm_f1);
                hf2 = h2_times_f(nm_f2);
                c0  = Q32_TWO - (hf1 - hf1 / 6);
                c1  = Q32_ONE + hf2 / 12;
                dn  = Q32_ONE + hf0 / 12;
                if (dn <= 0) begin
                    r.val = '0;
                    r.st  = ST_DIVZ;
                end else begin
                    a0  = c0;
                    a1  = c1;
                    b0  = $signed(nm_y1);
                    b1  = $signed(nm_y2);
                    dv  = dn;
                    num = a0 * b0 - a1 * b1;
                    quo = num / dv;
                    if (quo > Q_MAX) begin
                        r.val = Y_MAX;
                        r.st  = ST_SAT;
                    end else if (quo < Q_MIN) begin
                        r.val = Y_MIN;
                        r.st  = ST_SAT;
                    end else begin
                        r.val = quo[DATA_W-1:0];
                    end
                end
            end
        end
        nm_y2    = nm_y1;
        nm_y1    = r.val;
        nm_f2    = nm_f1;
        nm_f1    = f;
        nm_index = last_pt ? '0 : nm_index + 1'b1;
        r.last   = last_pt;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_small(input int span);
        return DATA_W'($urandom_range(2 * span, 0) - span);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_STEP_SQ:    cf_step_sq    = data;
            REG_START_POS:  cf_start_pos  = data;
            REG_GRID_STEP:  cf_grid_step  = data;
            REG_FIRST_VAL:  cf_first_val  = data;
            REG_SECOND_VAL: cf_second_val = data;
            REG_NUM_STEPS:  cf_num_steps  = data[IDX_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (f_backlog.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        row_t r;
        r.is_cfg    = 1'b1;
        r.idx       = idx;
        r.data      = data;
        r.smp.f     = '0;
        r.smp.typed = 1'b0;
        r.smp.want  = '0;
        dir_rows.push_back(r);
    endtask

    task automatic add_pt(input logic [DATA_W-1:0] f, input logic typed,
                          input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] val,
                          input logic last, input t_status st);
        row_t r;
        r.is_cfg         = 1'b0;
        r.idx            = '0;
        r.data           = '0;
        r.smp.f          = f;
        r.smp.typed      = typed;
        r.smp.want.pos   = pos;
        r.smp.want.val   = val;
        r.smp.want.last  = last;
        r.smp.want.st    = st;
        dir_rows.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want_point = numerov_next(cur_sample.f);
                expected_points.push_back(cur_sample.typed ? cur_sample.want : want_point);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (f_backlog.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
                    cur_sample = f_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_sample.f;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side ready, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_served   <= 1'b1;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= 31;
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_point.pos  = m_axis_tdata[DATA_W-1:0];
            got_point.val  = m_axis_tdata[2*DATA_W-1:DATA_W];
            got_point.last = m_axis_tlast;
            got_point.st   = t_status'(m_axis_tuser);
            if (expected_points.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual pos %h value %h",
                         $time, got_point.pos, got_point.val);
                mismatches++;
            end else begin
                want_point = expected_points.pop_front();
                check_field("position", want_point.pos, got_point.pos);
                check_field("value", want_point.val, got_point.val);
                check_field("last", DATA_W'(want_point.last), DATA_W'(got_point.last));
                check_field("status", DATA_W'(want_point.st), DATA_W'(got_point.st));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int ph;
        int k;
        logic [DATA_W-1:0] stp, sp, gs, y0, y1, fv;
        logic [IDX_W-1:0]  ns;
        sample_t smp;

        // after reset: defaults, two points per run
        add_pt(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK);
        add_pt(32'h7fff_ffff, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK);
        // extremes, zero step count, ignored indexes
        add_cfg(REG_STEP_SQ,    32'hffff_ffff);
        add_cfg(REG_START_POS,  32'h8000_0000);
        add_cfg(REG_GRID_STEP,  32'hffff_ffff);
        add_cfg(REG_FIRST_VAL,  32'h7fff_ffff);
        add_cfg(REG_SECOND_VAL, 32'h8000_0000);
        add_cfg(REG_NUM_STEPS,  32'hffff_0000);
        add_cfg(REG_NONE_LO,    32'hffff_ffff);
        add_cfg(REG_NONE_HI,    32'h1234_5678);
        add_pt(32'h8000_0000, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 1'b1, ST_OK);
        // harmonic oscillator, h = 0.1
        add_cfg(REG_NUM_STEPS,  32'h0000_0004);
        add_cfg(REG_STEP_SQ,    32'h028f_5c29);
        add_cfg(REG_START_POS,  32'h0000_0000);
        add_cfg(REG_GRID_STEP,  32'h0000_1999);
        add_cfg(REG_FIRST_VAL,  32'h0001_0000);
        add_cfg(REG_SECOND_VAL, 32'h0000_feb9);
        repeat (5) add_pt(32'h0001_0000, 1'b0, '0, '0, 1'b0, ST_OK);
        // positive saturation, then a clean point
        add_cfg(REG_STEP_SQ,    32'h0000_0000);
        add_cfg(REG_GRID_STEP,  32'h0001_0000);
        add_cfg(REG_FIRST_VAL,  32'h8000_0000);
        add_cfg(REG_SECOND_VAL, 32'h7fff_ffff);
        add_cfg(REG_NUM_STEPS,  32'h0000_0003);
        add_pt(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0, ST_OK);
        add_pt(32'h0000_0000, 1'b1, 32'h0001_0000, 32'h7fff_ffff, 1'b0, ST_OK);
        add_pt(32'h0000_0000, 1'b1, 32'h0002_0000, 32'h7fff_ffff, 1'b0, ST_SAT);
        add_pt(32'h0000_0000, 1'b1, 32'h0003_0000, 32'h7fff_ffff, 1'b1, ST_OK);
        // negative saturation
        add_cfg(REG_FIRST_VAL,  32'h7fff_ffff);
        add_cfg(REG_SECOND_VAL, 32'h8000_0000);
        add_cfg(REG_NUM_STEPS,  32'h0000_0002);
        add_pt(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h7fff_ffff, 1'b0, ST_OK);
        add_pt(32'h0000_0000, 1'b1, 32'h0001_0000, 32'h8000_0000, 1'b0, ST_OK);
        add_pt(32'h0000_0000, 1'b1, 32'h0002_0000, 32'h8000_0000, 1'b1, ST_SAT);
        // non-positive divisor, then full-scale f
        add_cfg(REG_STEP_SQ,    32'hffff_ffff);
        add_cfg(REG_FIRST_VAL,  32'h0001_0000);
        add_cfg(REG_SECOND_VAL, 32'h0001_0000);
        add_pt(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0001_0000, 1'b0, ST_OK);
        add_pt(32'h0000_0000, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, ST_OK);
        add_pt(32'h8000_0000, 1'b1, 32'h0002_0000, 32'h0000_0000, 1'b1, ST_DIVZ);
        repeat (3) add_pt(32'h7fff_ffff, 1'b0, '0, '0, 1'b0, ST_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                f_backlog.push_back(dir_rows[r].smp);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            calm <= (ph == CALM_PHASE);
            if (ph == HOLD_PHASE)
                hold_req <= 1'b1;
            stp = $urandom & 32'h0fff_ffff;
            sp  = $urandom;
            gs  = $urandom & 32'h0000_3fff;
            y0  = rand_small(32'h0004_0000);
            y1  = rand_small(32'h0004_0000);
            ns  = IDX_W'($urandom_range(40, 2));
            case (ph)
                1: begin
                    stp = '0;
                    ns  = '0;
                    sp  = 32'h7fff_ffff;
                    gs  = 32'hffff_ffff;
                end
                2: begin
                    stp = 32'hffff_ffff;
                    ns  = IDX_W'($urandom_range(12, 2));
                end
                3: begin
                    stp = $urandom;
                    gs  = $urandom;
                    y0  = $urandom;
                    y1  = $urandom;
                    ns  = IDX_W'($urandom_range(8, 1));
                end
                4: ns = 16'hffff;
                5: begin
                    ns = 16'd1;
                    sp = 32'h8000_0000;
                    gs = '0;
                end
                6: stp = $urandom;
                7: begin
                    y0 = Y_MAX;
                    y1 = Y_MIN;
                end
                default: ;
            endcase
            write_reg(REG_STEP_SQ, stp);
            write_reg(REG_START_POS, sp);
            write_reg(REG_GRID_STEP, gs);
            write_reg(REG_FIRST_VAL, y0);
            write_reg(REG_SECOND_VAL, y1);
            write_reg(REG_NUM_STEPS, {16'($urandom), ns});
            write_reg(REG_NONE_LO, $urandom);
            write_reg(REG_NONE_HI, $urandom);
            repeat (PHASE_ITEMS) begin
                k = $urandom_range(99);
                if (k < 60) begin
                    fv = rand_small(32'h0008_0000);
                end else if (k < 85) begin
                    fv = $urandom;
                end else begin
                    case ($urandom_range(3))
                        0: fv = 32'h7fff_ffff;
                        1: fv = 32'h8000_0000;
                        2: fv = 32'h0000_0000;
                        default: fv = 32'hffff_ffff;
                    endcase
                end
                smp.f     = fv;
                smp.typed = 1'b0;
                smp.want  = '0;
                f_backlog.push_back(smp);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
